@@ rtl/dlp_pkg.sv @@
// package for the directory entry long-name parser: codes, constants and the character table
package dlp_pkg;

    localparam int NAME_BUFFER_CHARS_DEF = 255;
    localparam int CHARS_PER_ENTRY       = 13;

    localparam logic [4:0] ENTRY_LAST_OFF = 5'd31;
    localparam logic [4:0] ENTRY_ATTR_OFF = 5'd11;
    localparam logic [4:0] ENTRY_ORD_OFF  = 5'd0;

    localparam logic [7:0] BYTE_END       = 8'h00;
    localparam logic [7:0] BYTE_DELETED   = 8'hE5;
    localparam logic [7:0] ATTR_MASK      = 8'h3F;
    localparam logic [7:0] ATTR_LFN       = 8'h0F;
    localparam logic [7:0] ORD_FIRST_MASK = 8'h40;
    localparam logic [7:0] ORD_SEQ_MASK   = 8'h1F;
    localparam logic [7:0] ORD_LAST       = 8'h01;

    localparam logic [3:0] CHAR_IDX_LAST = 4'(CHARS_PER_ENTRY - 1);

    typedef enum logic [2:0] {
        KIND_SHORT    = 3'd0,
        KIND_END      = 3'd1,
        KIND_DELETED  = 3'd2,
        KIND_LFN_LAST = 3'd3,
        KIND_LFN      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_GATHER,
        ST_READ,
        ST_CHAR,
        ST_SUM
    } state_t;

    // byte offset of the low byte of each name character in a long-name entry
    function automatic logic [4:0] char_byte_pos(input logic [3:0] idx);
        logic [4:0] pos;
        case (idx)
            4'd0:    pos = 5'd1;
            4'd1:    pos = 5'd3;
            4'd2:    pos = 5'd5;
            4'd3:    pos = 5'd7;
            4'd4:    pos = 5'd9;
            4'd5:    pos = 5'd14;
            4'd6:    pos = 5'd16;
            4'd7:    pos = 5'd18;
            4'd8:    pos = 5'd20;
            4'd9:    pos = 5'd22;
            4'd10:   pos = 5'd24;
            4'd11:   pos = 5'd28;
            4'd12:   pos = 5'd30;
            default: pos = 5'd1;
        endcase
        return pos;
    endfunction

endpackage

@@ rtl/dir_entry_lfn_parser.sv @@
// directory entry parser: gathers 32-byte entries, classifies them and emits long-name characters
// One byte is taken per cycle while an entry is gathered into a 32x8 entry memory, unless the
// result side stalls on the last byte. A short, deleted or end-of-directory entry gives its
// summary at the edge of the 32nd byte. A long-name entry then reads its 13 characters from
// the entry memory, each with a memory read into the registered read ports and then a load
// of the output register, and gives the summary after its last character; bytes are not
// taken meanwhile, and the result side can stall each character and the summary.
module dir_entry_lfn_parser #(
    parameter int NAME_BUFFER_CHARS = dlp_pkg::NAME_BUFFER_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_dir_byte,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_record_kind,
    output logic        m_is_char,
    output logic [15:0] m_name_char,
    output logic [7:0]  m_name_index,
    output logic [7:0]  m_name_length,
    output logic        m_sequence_error,
    output logic        m_last
);
    import dlp_pkg::*;

    localparam logic [7:0] NAME_TOP = 8'(NAME_BUFFER_CHARS);
    localparam logic [7:0] CHARS_8  = 8'(CHARS_PER_ENTRY);

    logic [7:0] mem [32];
    logic [7:0] rd_lo_reg, rd_hi_reg;
    logic [4:0] rd_lo_addr, rd_hi_addr;

    state_t     state_reg, state_next;
    logic [4:0] offset_reg, offset_next;
    logic [7:0] npos_reg, npos_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] attr_reg, attr_next;
    logic [7:0] base_reg, base_next;
    kind_t      kind_reg, kind_next;
    logic       err_reg, err_next;
    logic [3:0] cnt_reg, cnt_next;

    logic        m_valid_reg, m_valid_next;
    kind_t       m_kind_reg, m_kind_next;
    logic        m_is_char_reg, m_is_char_next;
    logic [15:0] m_char_reg, m_char_next;
    logic [7:0]  m_index_reg, m_index_next;
    logic [7:0]  m_length_reg, m_length_next;
    logic        m_err_reg, m_err_next;
    logic        m_last_reg, m_last_next;

    logic       accept, complete, out_free;
    logic [4:0] eff_off;
    logic [7:0] eff_npos;
    logic       is_end, is_del, is_lfn, lfn_last, lfn_err;
    logic [7:0] lfn_pos;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign eff_off  = s_restart ? 5'd0 : offset_reg;
    assign eff_npos = s_restart ? NAME_TOP : npos_reg;
    assign complete = accept && (eff_off == ENTRY_LAST_OFF);

    assign is_end   = (first_reg == BYTE_END);
    assign is_del   = (first_reg == BYTE_DELETED);
    assign is_lfn   = ((attr_reg & ATTR_MASK) == ATTR_LFN);
    assign lfn_last = ((first_reg & ORD_SEQ_MASK) == ORD_LAST);
    assign lfn_err  = (((first_reg & ORD_FIRST_MASK) != 8'd0) && (eff_npos != NAME_TOP))
                      || (eff_npos < CHARS_8);
    assign lfn_pos  = (eff_npos < CHARS_8) ? 8'd0 : 8'(eff_npos - CHARS_8);

    assign rd_lo_addr = char_byte_pos(cnt_reg);
    assign rd_hi_addr = 5'(rd_lo_addr + 5'd1);

    // entry memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[eff_off] <= s_dir_byte;
        end
        rd_lo_reg <= mem[rd_lo_addr];
        rd_hi_reg <= mem[rd_hi_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_GATHER: begin
                if (complete && !is_end && !is_del && is_lfn) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CHAR;
            end
            ST_CHAR: begin
                if (out_free) begin
                    state_next = (cnt_reg == CHAR_IDX_LAST) ? ST_SUM : ST_READ;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    state_next = ST_GATHER;
                end
            end
            default: state_next = ST_GATHER;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == ST_GATHER) && (out_free || offset_reg != ENTRY_LAST_OFF);
    end

    // datapath
    always_comb begin
        offset_next    = offset_reg;
        npos_next      = npos_reg;
        first_next     = first_reg;
        attr_next      = attr_reg;
        base_next      = base_reg;
        kind_next      = kind_reg;
        err_next       = err_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_is_char_next = m_is_char_reg;
        m_char_next    = m_char_reg;
        m_index_next   = m_index_reg;
        m_length_next  = m_length_reg;
        m_err_next     = m_err_reg;
        m_last_next    = m_last_reg;

        if (accept) begin
            offset_next = 5'(eff_off + 5'd1);
            npos_next   = eff_npos;
            if (eff_off == ENTRY_ORD_OFF) begin
                first_next = s_dir_byte;
            end
            if (eff_off == ENTRY_ATTR_OFF) begin
                attr_next = s_dir_byte;
            end
        end

        if (complete) begin
            if (is_end || is_del || !is_lfn) begin
                m_valid_next   = 1'b1;
                m_kind_next    = is_end ? KIND_END : (is_del ? KIND_DELETED : KIND_SHORT);
                m_is_char_next = 1'b0;
                m_char_next    = 16'd0;
                m_index_next   = 8'd0;
                m_length_next  = 8'd0;
                m_err_next     = 1'b0;
                m_last_next    = 1'b1;
            end else begin
                base_next = lfn_pos;
                err_next  = lfn_err;
                kind_next = lfn_last ? KIND_LFN_LAST : KIND_LFN;
                cnt_next  = 4'd0;
                npos_next = lfn_last ? NAME_TOP : lfn_pos;
            end
        end

        if (state_reg == ST_CHAR && out_free) begin
            m_valid_next   = 1'b1;
            m_kind_next    = kind_reg;
            m_is_char_next = 1'b1;
            m_char_next    = {rd_hi_reg, rd_lo_reg};
            m_index_next   = 8'(base_reg + {4'd0, cnt_reg});
            m_length_next  = 8'd0;
            m_err_next     = err_reg;
            m_last_next    = 1'b0;
            cnt_next       = 4'(cnt_reg + 4'd1);
        end

        if (state_reg == ST_SUM && out_free) begin
            m_valid_next   = 1'b1;
            m_kind_next    = kind_reg;
            m_is_char_next = 1'b0;
            m_char_next    = 16'd0;
            m_index_next   = 8'd0;
            m_length_next  = (kind_reg == KIND_LFN_LAST) ? 8'(NAME_TOP - base_reg) : 8'd0;
            m_err_next     = err_reg;
            m_last_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_GATHER;
            offset_reg  <= 5'd0;
            npos_reg    <= NAME_TOP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            offset_reg  <= offset_next;
            npos_reg    <= npos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg     <= first_next;
        attr_reg      <= attr_next;
        base_reg      <= base_next;
        kind_reg      <= kind_next;
        err_reg       <= err_next;
        cnt_reg       <= cnt_next;
        m_kind_reg    <= m_kind_next;
        m_is_char_reg <= m_is_char_next;
        m_char_reg    <= m_char_next;
        m_index_reg   <= m_index_next;
        m_length_reg  <= m_length_next;
        m_err_reg     <= m_err_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_record_kind    = m_kind_reg;
    assign m_is_char        = m_is_char_reg;
    assign m_name_char      = m_char_reg;
    assign m_name_index     = m_index_reg;
    assign m_name_length    = m_length_reg;
    assign m_sequence_error = m_err_reg;
    assign m_last           = m_last_reg;

endmodule

@@ rtl/dlp_checker.sv @@
// port-level assertions for the directory entry parser and their bind
module dlp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_dir_byte,
    input logic        s_restart,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_record_kind,
    input logic        m_is_char,
    input logic [15:0] m_name_char,
    input logic [7:0]  m_name_index,
    input logic [7:0]  m_name_length,
    input logic        m_sequence_error,
    input logic        m_last
);
    import dlp_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_dir_byte) && $stable(s_restart))
        else $error("waiting input item changed");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_name_char) && $stable(m_last)
            && $stable(m_record_kind) && $stable(m_is_char) && $stable(m_name_index)
            && $stable(m_name_length) && $stable(m_sequence_error))
        else $error("stalled result item changed");

    a_last_iff_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last != m_is_char))
        else $error("last and is_char disagree");

    a_char_is_lfn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_char |-> (m_record_kind == KIND_LFN || m_record_kind == KIND_LFN_LAST))
        else $error("name character on a non long-name entry");

    a_plain_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_record_kind == KIND_SHORT || m_record_kind == KIND_END
            || m_record_kind == KIND_DELETED)
        |-> m_name_length == 8'd0 && !m_sequence_error && m_name_char == 16'd0)
        else $error("plain entry summary carries long-name data");

endmodule

bind dir_entry_lfn_parser dlp_checker u_dlp_checker (.*);

@@ bench/dir_entry_lfn_parser_tb.sv @@
// testbench for the directory entry long-name parser: directed and random byte streams against a scoreboard
`timescale 1ns / 1ps

typedef struct {
    dlp_pkg::kind_t kind;
    bit             is_char;
    bit [15:0]      name_char;
    bit [7:0]       name_index;
    bit [7:0]       name_length;
    bit             seq_err;
    bit             last;
} lfn_result_t;

localparam bit [7:0] NAME_TOP = 8'(dlp_pkg::NAME_BUFFER_CHARS_DEF);

class dir_scoreboard;
    bit [7:0]    entry_buf [32];
    bit [4:0]    fill_pos;
    bit [7:0]    name_pos;
    lfn_result_t due_results [$];
    int          failures;
    int          checked;
    int          n_lfn;
    int          n_flagged;
    int          n_short;
    int          n_deleted;
    int          n_end;

    function new();
        fill_pos = '0;
        name_pos = NAME_TOP;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    // low byte offset of name character i within a long-name entry
    function int char_offset(int i);
        if (i < 5) return 1 + 2 * i;
        if (i < 11) return 4 + 2 * i;
        return 6 + 2 * i;
    endfunction

    function void push(dlp_pkg::kind_t kind, bit is_char, bit [15:0] ch, bit [7:0] idx,
                       bit [7:0] len, bit err, bit last);
        lfn_result_t r;
        r.kind        = kind;
        r.is_char     = is_char;
        r.name_char   = ch;
        r.name_index  = idx;
        r.name_length = len;
        r.seq_err     = err;
        r.last        = last;
        due_results.push_back(r);
    endfunction

    function void take_byte(bit [7:0] b, bit rst);
        bit [7:0]       ord;
        bit [7:0]       pos;
        bit             err;
        bit             closing;
        int             off;
        dlp_pkg::kind_t kind;
        if (rst) begin
            fill_pos = '0;
            name_pos = NAME_TOP;
        end
        entry_buf[fill_pos] = b;
        if (fill_pos != dlp_pkg::ENTRY_LAST_OFF) begin
            fill_pos++;
            return;
        end
        fill_pos = '0;
        ord = entry_buf[dlp_pkg::ENTRY_ORD_OFF];
        if (ord == dlp_pkg::BYTE_END) begin
            n_end++;
            push(dlp_pkg::KIND_END, 0, 0, 0, 0, 0, 1);
            return;
        end
        if (ord == dlp_pkg::BYTE_DELETED) begin
            n_deleted++;
            push(dlp_pkg::KIND_DELETED, 0, 0, 0, 0, 0, 1);
            return;
        end
        if ((entry_buf[dlp_pkg::ENTRY_ATTR_OFF] & dlp_pkg::ATTR_MASK) != dlp_pkg::ATTR_LFN) begin
            n_short++;
            push(dlp_pkg::KIND_SHORT, 0, 0, 0, 0, 0, 1);
            return;
        end
        err = ((ord & dlp_pkg::ORD_FIRST_MASK) != 0) && (name_pos != NAME_TOP);
        // underflow saturates at the bottom of the buffer
        if (name_pos < dlp_pkg::CHARS_PER_ENTRY) begin
            err = 1'b1;
            pos = '0;
        end else begin
            pos = name_pos - 8'(dlp_pkg::CHARS_PER_ENTRY);
        end
        name_pos = pos;
        closing  = (ord & dlp_pkg::ORD_SEQ_MASK) == dlp_pkg::ORD_LAST;
        kind     = closing ? dlp_pkg::KIND_LFN_LAST : dlp_pkg::KIND_LFN;
        for (int i = 0; i < dlp_pkg::CHARS_PER_ENTRY; i++) begin
            off = char_offset(i);
            push(kind, 1, {entry_buf[off + 1], entry_buf[off]}, pos + 8'(i), 0, err, 0);
        end
        push(kind, 0, 0, 0, closing ? NAME_TOP - pos : 8'd0, err, 1);
        if (closing) name_pos = NAME_TOP;
        n_lfn++;
        if (err) n_flagged++;
    endfunction

    function void check_result(logic [2:0] kind, logic is_char, logic [15:0] ch,
                               logic [7:0] idx, logic [7:0] len, logic err, logic last);
        lfn_result_t r;
        checked++;
        if (due_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: kind=%0d is_char=%0b char=%h", kind, is_char, ch,
                         " idx=%0d len=%0d err=%0b last=%0b", idx, len, err, last);
            return;
        end
        r = due_results.pop_front();
        if (r.kind !== kind || r.is_char !== is_char || r.name_char !== ch ||
            r.name_index !== idx || r.name_length !== len || r.seq_err !== err ||
            r.last !== last) begin
            failures++;
            if (failures <= 10) begin
                $display("mismatch: expected kind=%0d is_char=%0b char=%h",
                         r.kind, r.is_char, r.name_char,
                         " idx=%0d len=%0d err=%0b last=%0b",
                         r.name_index, r.name_length, r.seq_err, r.last);
                $display("          actual   kind=%0d is_char=%0b char=%h", kind, is_char, ch,
                         " idx=%0d len=%0d err=%0b last=%0b", idx, len, err, last);
            end
        end
    endfunction
endclass

module dir_entry_lfn_parser_tb;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_dir_byte = '0;
    logic        s_restart = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_record_kind;
    logic        m_is_char;
    logic [15:0] m_name_char;
    logic [7:0]  m_name_index;
    logic [7:0]  m_name_length;
    logic        m_sequence_error;
    logic        m_last;

    dir_scoreboard sb = new();
    bit            calm = 1'b0;
    int            bytes_sent = 0;

    dir_entry_lfn_parser dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_dir_byte       (s_dir_byte),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_record_kind    (m_record_kind),
        .m_is_char        (m_is_char),
        .m_name_char      (m_name_char),
        .m_name_index     (m_name_index),
        .m_name_length    (m_name_length),
        .m_sequence_error (m_sequence_error),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [7:0] rand_first();
        bit [7:0] b;
        do b = 8'($urandom);
        while (b == dlp_pkg::BYTE_END || b == dlp_pkg::BYTE_DELETED);
        return b;
    endfunction

    function automatic bit [7:0] short_attr();
        bit [7:0] a;
        a = 8'($urandom);
        if ((a & dlp_pkg::ATTR_MASK) == dlp_pkg::ATTR_LFN) a ^= 8'h10;
        return a;
    endfunction

    function automatic bit [7:0] lfn_attr();
        return (8'($urandom) & ~dlp_pkg::ATTR_MASK) | dlp_pkg::ATTR_LFN;
    endfunction

    // result side: random stalls, every accepted result goes to the scoreboard
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_record_kind, m_is_char, m_name_char, m_name_index,
                                m_name_length, m_sequence_error, m_last);
            if (stall_left > 0) stall_left--;
            else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            m_ready <= (stall_left == 0);
        end
    end

    task automatic send_byte(input bit [7:0] b, input bit rst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_dir_byte <= b;
        s_restart  <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_byte(b, rst);
        bytes_sent++;
    endtask

    task automatic send_entry(input bit [7:0] first, input bit [7:0] attr, input bit rst,
                              input fill_t fill = FILL_RANDOM);
        bit [7:0] e [32];
        for (int i = 0; i < 32; i++)
            e[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
        e[dlp_pkg::ENTRY_ORD_OFF]  = first;
        e[dlp_pkg::ENTRY_ATTR_OFF] = attr;
        for (int i = 0; i < 32; i++)
            send_byte(e[i], rst && i == 0);
    endtask

    // well-formed long-name set of n entries followed by its short alias
    task automatic send_name_set(input int n, input bit rst);
        bit [7:0] ord;
        for (int k = n; k >= 1; k--) begin
            ord = 8'(k) | (8'($urandom) & 8'hA0);
            if (k == n) ord |= dlp_pkg::ORD_FIRST_MASK;
            send_entry(ord, lfn_attr(), rst && k == n);
        end
        send_entry(rand_first(), short_attr(), 1'b0);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int  pick;
        bit  paused;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        send_entry(8'hFF, 8'h00, 1'b1, FILL_RANDOM);
        send_entry(dlp_pkg::BYTE_END, dlp_pkg::ATTR_LFN, 1'b0);
        send_entry(dlp_pkg::BYTE_DELETED, dlp_pkg::ATTR_LFN, 1'b0);
        send_entry(8'h41, 8'h8F, 1'b0, FILL_ONES);
        // misplaced first entry of a set, short entry inside the set
        send_entry(8'h42, dlp_pkg::ATTR_LFN, 1'b0);
        send_entry(8'h45, dlp_pkg::ATTR_LFN, 1'b0);
        send_entry(rand_first(), 8'h20, 1'b0);
        send_entry(8'h01, 8'hCF, 1'b0, FILL_ZERO);
        // restart in the middle of an entry
        repeat (10) send_byte(8'($urandom), 1'b0);
        send_entry(8'h41, dlp_pkg::ATTR_LFN, 1'b1);

        // random
        paused = 1'b0;
        while (bytes_sent < 448) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_name_set($urandom_range(1, 3), $urandom_range(0, 7) == 0);
            end else if (pick < 80) begin
                send_entry(8'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
            end else if (pick < 88) begin
                send_entry($urandom_range(0, 1) ? dlp_pkg::BYTE_END : dlp_pkg::BYTE_DELETED,
                           8'($urandom), 1'b0);
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 3)) send_entry(rand_first(), lfn_attr(), 1'b0);
            end else begin
                repeat ($urandom_range(1, 31)) send_byte(8'($urandom), 1'b0);
                send_entry(rand_first(), short_attr(), 1'b1);
            end
            if (!paused && bytes_sent >= 352) begin
                wait_idle();
                paused = 1'b1;
            end
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("run covered %0d bytes in %0d entries: %0d long-name (%0d flagged), %0d short,",
                 bytes_sent, sb.n_lfn + sb.n_short + sb.n_deleted + sb.n_end, sb.n_lfn,
                 sb.n_flagged, sb.n_short);
        $display("%0d deleted, %0d end markers; %0d results checked, %0d failures, %0d missing",
                 sb.n_deleted, sb.n_end, sb.checked, sb.failures, sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
